// ===== hw/rtl/iexp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the infix expression evaluator.
// Used by every module of the block; depends on nothing.

package iexp_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

   localparam logic [7:0] CHAR_ZERO   = 8'd48;
   localparam logic [7:0] CHAR_NINE   = 8'd57;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_TIMES  = 8'h2A;
   localparam logic [7:0] CHAR_DIVIDE = 8'h2F;

   typedef enum logic [1:0] {
      OP_PLUS   = 2'd0,
      OP_MINUS  = 2'd1,
      OP_TIMES  = 2'd2,
      OP_DIVIDE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PH_FIRST     = 2'd0,
      PH_AFTER_OP  = 2'd1,
      PH_IN_NUMBER = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_SYNTAX  = 2'd1,
      ERR_RANGE   = 2'd2,
      ERR_DIVZERO = 2'd3
   } err_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [1:0]                    error;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic consume;
      logic fin_add;
      logic mul_load;
      logic mul_write;
      logic div_zero;
      logic div_start;
      logic div_write;
      logic op_apply;
      logic syntax_err;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic   err_set;
      logic   fin_needed;
      op_type pend;
      logic   num_zero;
      logic   phase_in;
      logic   last;
      logic   div_done;
      logic   out_free;
   } stat_type;

endpackage

// ===== hw/rtl/iexp_div.sv =====
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle, unsigned operands.
// Uses iexp_pkg for the default width.

module iexp_div #(
   parameter int WIDTH = iexp_pkg::VALUE_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;

   always_comb begin
      trial   = {rem_ff, quo_ff[WIDTH-1]} - {1'b0, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (!trial[WIDTH]) begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WIDTH-2:0], quo_ff[WIDTH-1]};
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/iexp_dp.sv =====
`timescale 1ns / 1ps
// Datapath: accumulators, number parser, multiplier, divider and result register.
// Driven by iexp_ctrl commands; uses iexp_pkg and iexp_div.

module iexp_dp #(
   parameter int MAX_DIGITS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  iexp_pkg::cmd_type  cmd,
   input  iexp_pkg::req_type  req_data,
   input  logic               rsp_stall,
   output iexp_pkg::stat_type stat,
   output logic               rsp_valid,
   output iexp_pkg::rsp_type  rsp_data
);

   localparam int VW  = iexp_pkg::VALUE_WIDTH;
   localparam int DCW = $clog2(MAX_DIGITS + 2);

   logic [7:0]          ch_ff, ch_in;
   logic                last_ff, last_in;
   logic [VW-1:0]       sum_ff, sum_in;
   logic [VW-1:0]       term_ff, term_in;
   logic [VW-1:0]       num_ff, num_in;
   logic [DCW-1:0]      dcount_ff, dcount_in;
   iexp_pkg::op_type    pend_ff, pend_in;
   iexp_pkg::phase_type phase_ff, phase_in;
   iexp_pkg::err_type   err_ff, err_in;
   logic [VW-1:0]       prod_ff, prod_in;
   logic                neg_ff, neg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   iexp_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                is_op;
   iexp_pkg::op_type    ch_op;
   logic                is_digit;
   logic [7:0]          digit_diff;
   logic [VW+3:0]       num_wide;
   logic [DCW-1:0]      dcount_inc;
   logic                num_bad;
   logic                do_number;
   logic [VW-1:0]       mag;
   logic [VW-1:0]       sum_total;
   logic                div_done;
   logic [VW-1:0]       div_quo;

   always_comb begin
      is_op = 1'b1;
      ch_op = iexp_pkg::OP_PLUS;
      unique case (ch_ff)
         iexp_pkg::CHAR_PLUS:   ch_op = iexp_pkg::OP_PLUS;
         iexp_pkg::CHAR_MINUS:  ch_op = iexp_pkg::OP_MINUS;
         iexp_pkg::CHAR_TIMES:  ch_op = iexp_pkg::OP_TIMES;
         iexp_pkg::CHAR_DIVIDE: ch_op = iexp_pkg::OP_DIVIDE;
         default:               is_op = 1'b0;
      endcase
   end

   assign is_digit   = (ch_ff >= iexp_pkg::CHAR_ZERO) && (ch_ff <= iexp_pkg::CHAR_NINE);
   assign digit_diff = ch_ff - iexp_pkg::CHAR_ZERO;
   assign num_wide   = ({4'b0000, num_ff} << 3) + ({4'b0000, num_ff} << 1)
                     + {{VW{1'b0}}, digit_diff[3:0]};
   assign dcount_inc = dcount_ff + 1'b1;
   assign num_bad    = (dcount_inc > DCW'(MAX_DIGITS)) || !is_digit
                     || (num_wide > {4'b0000, iexp_pkg::VALUE_MAX});
   assign mag        = term_ff[VW-1] ? (~term_ff + 1'b1) : term_ff;
   assign sum_total  = sum_ff + term_ff;

   iexp_div #(
      .WIDTH (VW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (mag),
      .divisor  (num_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      ch_in        = ch_ff;
      last_in      = last_ff;
      sum_in       = sum_ff;
      term_in      = term_ff;
      num_in       = num_ff;
      dcount_in    = dcount_ff;
      pend_in      = pend_ff;
      phase_in     = phase_ff;
      err_in       = err_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      do_number    = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.capture) begin
         ch_in   = req_data.ch;
         last_in = req_data.last;
      end

      if (cmd.consume) begin
         unique case (phase_ff) inside
            iexp_pkg::PH_FIRST: begin
               if (is_op) begin
                  if (ch_op == iexp_pkg::OP_TIMES || ch_op == iexp_pkg::OP_DIVIDE) begin
                     err_in = iexp_pkg::ERR_SYNTAX;
                  end else begin
                     pend_in  = ch_op;
                     phase_in = iexp_pkg::PH_AFTER_OP;
                  end
               end else begin
                  pend_in   = iexp_pkg::OP_PLUS;
                  do_number = 1'b1;
               end
            end
            iexp_pkg::PH_AFTER_OP, iexp_pkg::PH_IN_NUMBER: begin
               do_number = 1'b1;
            end
            default: begin
               do_number = 1'b0;
            end
         endcase
      end

      if (do_number) begin
         dcount_in = dcount_inc;
         if (num_bad) begin
            err_in = iexp_pkg::ERR_RANGE;
         end else begin
            num_in   = num_wide[VW-1:0];
            phase_in = iexp_pkg::PH_IN_NUMBER;
         end
      end

      if (cmd.fin_add) begin
         sum_in  = sum_total;
         term_in = (pend_ff == iexp_pkg::OP_MINUS) ? (~num_ff + 1'b1) : num_ff;
      end

      if (cmd.mul_load) begin
         prod_in = term_ff * num_ff;
      end

      if (cmd.mul_write) begin
         term_in = prod_ff;
      end

      if (cmd.div_zero) begin
         err_in = iexp_pkg::ERR_DIVZERO;
      end

      if (cmd.div_start) begin
         neg_in = term_ff[VW-1];
      end

      if (cmd.div_write) begin
         term_in = neg_ff ? (~div_quo + 1'b1) : div_quo;
      end

      if (cmd.fin_add || cmd.mul_write || cmd.div_zero || cmd.div_write) begin
         num_in    = '0;
         dcount_in = '0;
      end

      if (cmd.op_apply) begin
         pend_in  = ch_op;
         phase_in = iexp_pkg::PH_AFTER_OP;
      end

      if (cmd.syntax_err) begin
         err_in = iexp_pkg::ERR_SYNTAX;
      end

      if (cmd.out_load) begin
         rsp_data_in.value = (err_ff == iexp_pkg::ERR_NONE) ? sum_total : '0;
         rsp_data_in.error = err_ff;
         rsp_valid_in      = 1'b1;
         sum_in            = '0;
         term_in           = '0;
         num_in            = '0;
         dcount_in         = '0;
         pend_in           = iexp_pkg::OP_PLUS;
         phase_in          = iexp_pkg::PH_FIRST;
         err_in            = iexp_pkg::ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         sum_ff       <= '0;
         term_ff      <= '0;
         num_ff       <= '0;
         dcount_ff    <= '0;
         pend_ff      <= iexp_pkg::OP_PLUS;
         phase_ff     <= iexp_pkg::PH_FIRST;
         err_ff       <= iexp_pkg::ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         term_ff      <= term_in;
         num_ff       <= num_in;
         dcount_ff    <= dcount_in;
         pend_ff      <= pend_in;
         phase_ff     <= phase_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      stat.err_set    = (err_ff != iexp_pkg::ERR_NONE);
      stat.fin_needed = is_op && (phase_ff == iexp_pkg::PH_IN_NUMBER);
      stat.pend       = pend_ff;
      stat.num_zero   = (num_ff == '0);
      stat.phase_in   = (phase_ff == iexp_pkg::PH_IN_NUMBER);
      stat.last       = last_ff;
      stat.div_done   = div_done;
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/iexp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences capture, parsing, term updates and result.
// Talks to iexp_dp through iexp_pkg command and status structs.

module iexp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  iexp_pkg::stat_type stat,
   output iexp_pkg::cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_STEP = 7'b0000010,
      S_FIN  = 7'b0000100,
      S_MUL  = 7'b0001000,
      S_DIV  = 7'b0010000,
      S_ENDC = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      ctx_end_ff, ctx_end_in;
   logic      fin_done;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      ctx_end_in = ctx_end_ff;
      fin_done   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_STEP;
            end
         end
         S_STEP: begin
            if (stat.err_set) begin
               state_in = stat.last ? S_ENDC : S_IDLE;
            end else if (stat.fin_needed) begin
               ctx_end_in = 1'b0;
               state_in   = S_FIN;
            end else begin
               cmd.consume = 1'b1;
               state_in    = stat.last ? S_ENDC : S_IDLE;
            end
         end
         S_FIN: begin
            unique case (stat.pend) inside
               iexp_pkg::OP_PLUS, iexp_pkg::OP_MINUS: begin
                  cmd.fin_add = 1'b1;
                  fin_done    = 1'b1;
               end
               iexp_pkg::OP_TIMES: begin
                  cmd.mul_load = 1'b1;
                  state_in     = S_MUL;
               end
               default: begin
                  if (stat.num_zero) begin
                     cmd.div_zero = 1'b1;
                     fin_done     = 1'b1;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIV;
                  end
               end
            endcase
         end
         S_MUL: begin
            cmd.mul_write = 1'b1;
            fin_done      = 1'b1;
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.div_write = 1'b1;
               fin_done      = 1'b1;
            end
         end
         S_ENDC: begin
            if (stat.err_set) begin
               state_in = S_OUT;
            end else if (!stat.phase_in) begin
               cmd.syntax_err = 1'b1;
               state_in       = S_OUT;
            end else begin
               ctx_end_in = 1'b1;
               state_in   = S_FIN;
            end
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin_done) begin
         if (ctx_end_ff) begin
            state_in = S_OUT;
         end else begin
            cmd.op_apply = 1'b1;
            state_in     = stat.last ? S_ENDC : S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ctx_end_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ctx_end_ff <= ctx_end_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== hw/rtl/infix_expression_evaluator.sv =====
`timescale 1ns / 1ps
// Top level of the infix expression evaluator: controller plus datapath.
// Uses iexp_pkg, iexp_ctrl and iexp_dp.
//
//   channel | ports                          | moves
//   --------+--------------------------------+-----------------------------
//   req     | req_valid, req_stall, req_data | one character and last flag
//   rsp     | rsp_valid, rsp_stall, rsp_data | value and error code
//
// A character that extends a number or is an operator after the first passes
// through the capture and step states. One that ends a number adds the term
// update: an add for + or -, a multiply load and write for *, and a divider run
// for / (the divider retires one quotient bit per cycle). The last character
// adds an end check, the final term update and the load of the result
// register, which waits while rsp_stall holds a previous result. Reset is
// synchronous and returns to the start of an expression.

module infix_expression_evaluator #(
   parameter int MAX_DIGITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  iexp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output iexp_pkg::rsp_type rsp_data
);

   iexp_pkg::cmd_type  cmd;
   iexp_pkg::stat_type stat;

   iexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   iexp_dp #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall
   ) else $error("controller took a transaction without leaving idle");

   a_div_done_clears: assert property (
      @(posedge clock) disable iff (reset)
      cmd.div_start |=> !stat.div_done
   ) else $error("divider reports done right after start");

   a_error_zero_value: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.error != iexp_pkg::ERR_NONE) |-> (rsp_data.value == '0)
   ) else $error("errored transaction carries a nonzero value");

   a_result_only_from_end: assert property (
      @(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.last
   ) else $error("result loaded for a character not marked last");
`endif

endmodule
